>>> rtl/core/uia_pkg.sv
// Shared constants, status codes and table control types for the unique ID allocator.
package uia_pkg;

  // Identifier width and table geometry.
  localparam int unsigned ID_W    = 32;
  localparam int unsigned MAX_IDS = 64;
  localparam int unsigned IDX_W   = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

  // Hint raise step and the width of a remainder modulo that step.
  localparam int unsigned HINT_STEP = 100000;
  localparam int unsigned REM_W     = $clog2(HINT_STEP);

  // Division by the hint step as a shift and a reciprocal multiply. The step is 3125 times 32,
  // and for any 27-bit x the quotient x / 3125 equals (x * RECIP_MUL) >> RECIP_SHIFT.
  localparam int unsigned DIV_PRE_SHIFT = 5;
  localparam int unsigned DIV_IN_W      = ID_W - DIV_PRE_SHIFT;
  localparam int unsigned RECIP_W       = 28;
  localparam int unsigned RECIP_MUL     = 175921861;
  localparam int unsigned RECIP_SHIFT   = 39;
  localparam int unsigned QUO_W         = DIV_IN_W + RECIP_W - RECIP_SHIFT;

  // Command codes.
  localparam logic CMD_ALLOCATE = 1'b0;
  localparam logic CMD_RELEASE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_RELEASED  = 2'd3;

  // Control bundle from the sequencer to the ID table.
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             clr_en;
    logic [IDX_W-1:0] addr;
  } tbl_ctrl_t;

endpackage

>>> rtl/core/uia_table.sv
// Table of in-use IDs: one-port memory with registered read plus per-entry valid flags.
module uia_table
  import uia_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tbl_ctrl_t       ctrl_i,
  input  logic [ID_W-1:0] wr_data_i,
  output logic [ID_W-1:0] rd_data_o,
  output logic            rd_valid_o
);

  logic [ID_W-1:0]    mem [MAX_IDS];
  logic [ID_W-1:0]    rd_data_q;
  logic [MAX_IDS-1:0] valid_q;
  logic               rd_valid_q;

  // Entry storage; contents are only meaningful where the valid flag is set.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.addr] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[ctrl_i.addr];
    end
  end

  // Valid flags, cleared at once by reset, and the registered flag of the entry read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[ctrl_i.addr] <= 1'b1;
      end else if (ctrl_i.clr_en) begin
        valid_q[ctrl_i.addr] <= 1'b0;
      end
      if (ctrl_i.rd_en) begin
        rd_valid_q <= valid_q[ctrl_i.addr];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

>>> rtl/core/unique_id_allocator.sv
// Unique ID allocator: sequencer, hint raise unit and table scan.
// Release: accept, one table scan that stops at the matching entry or at the last one, then emit.
// Allocate: accept, then the divide, remainder and raise steps when the hint is below the minimum,
// a table scan per candidate for at most MAX_IDS+1 candidates, then insert and emit.
// One item at a time; a finished beat waits in the output register while the next is taken.
// Reset clears all valid flags at once and sets the minimum to zero; no clearing pass.
module unique_id_allocator
  import uia_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // Configuration write channel.
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [ID_W-1:0] cfg_data_i,
  // Request channel.
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            command_i,
  input  logic [ID_W-1:0] start_hint_i,
  input  logic [ID_W-1:0] release_id_i,
  // Result channel.
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [ID_W-1:0] given_id_o,
  output logic [1:0]      status_o,
  output logic            was_present_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_REM,
    S_RAISE,
    S_RD,
    S_CMP,
    S_FINISH,
    S_EMIT
  } state_e;

  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(MAX_IDS - 1);
  localparam logic [ID_W:0]      STEP_W   = (ID_W + 1)'(HINT_STEP);
  localparam logic [ID_W-1:0]    STEP_ID  = ID_W'(HINT_STEP);
  localparam logic [RECIP_W-1:0] RECIP_K  = RECIP_W'(RECIP_MUL);

  state_e               state_q;
  logic                 cmd_q;
  logic [ID_W-1:0]      key_q;
  logic [ID_W-1:0]      min_q;
  logic [ID_W-1:0]      gap_q;
  logic [QUO_W-1:0]     quo_q;
  logic [REM_W-1:0]     rem_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 free_found_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic [ID_W-1:0]      res_id_q;
  logic [1:0]           res_status_q;
  logic                 res_present_q;
  logic                 out_valid_q;
  logic [ID_W-1:0]      given_id_q;
  logic [1:0]           status_q;
  logic                 was_present_q;

  tbl_ctrl_t            tbl_ctrl;
  logic [ID_W-1:0]      tbl_rd_data;
  logic                 tbl_rd_valid;

  logic                        in_take;
  logic                        out_free;
  logic [DIV_IN_W+RECIP_W-1:0] recip_prod;
  logic [ID_W-1:0]             quo_scaled;
  logic [ID_W-1:0]             rem_full;
  logic [ID_W:0]               raised;
  logic                        hit;
  logic                        last_entry;

  assign in_take  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Remainder unit: the quotient by reciprocal multiplication, the remainder in the cycle after it.
  assign recip_prod = {{RECIP_W{1'b0}}, gap_q[ID_W-1:DIV_PRE_SHIFT]}
                    * {{DIV_IN_W{1'b0}}, RECIP_K};
  assign quo_scaled = {{(ID_W - QUO_W){1'b0}}, quo_q} * STEP_ID;
  assign rem_full   = gap_q - quo_scaled;

  // Raised hint: minimum less the remainder, plus one step when the remainder is non-zero.
  assign raised = {1'b0, min_q} - {{(ID_W + 1 - REM_W){1'b0}}, rem_q}
                + ((rem_q != '0) ? STEP_W : '0);

  // Compare stage of the table scan.
  assign hit        = tbl_rd_valid && (tbl_rd_data == key_q);
  assign last_entry = (idx_q == LAST_IDX);

  // Table control from the sequencer state.
  always_comb begin
    tbl_ctrl        = '0;
    tbl_ctrl.addr   = idx_q;
    tbl_ctrl.rd_en  = (state_q == S_RD);
    tbl_ctrl.clr_en = (state_q == S_CMP) && (cmd_q == CMD_RELEASE) && hit;
    if (state_q == S_FINISH) begin
      tbl_ctrl.addr  = free_idx_q;
      tbl_ctrl.wr_en = free_found_q;
    end
  end

  uia_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (tbl_ctrl),
    .wr_data_i  (key_q),
    .rd_data_o  (tbl_rd_data),
    .rd_valid_o (tbl_rd_valid)
  );

  // Sequencer, configuration register and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cmd_q         <= CMD_ALLOCATE;
      key_q         <= '0;
      min_q         <= '0;
      gap_q         <= '0;
      quo_q         <= '0;
      rem_q         <= '0;
      idx_q         <= '0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      res_id_q      <= '0;
      res_status_q  <= ST_ALLOCATED;
      res_present_q <= 1'b0;
      out_valid_q   <= 1'b0;
      given_id_q    <= '0;
      status_q      <= ST_ALLOCATED;
      was_present_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        min_q <= cfg_data_i;
      end

      // The output beat leaves when it is taken, unless a new one replaces it.
      if (out_valid_q && !out_stall_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_take) begin
            cmd_q         <= command_i;
            idx_q         <= '0;
            free_found_q  <= 1'b0;
            res_id_q      <= '0;
            res_present_q <= 1'b0;
            if (command_i == CMD_RELEASE) begin
              key_q   <= release_id_i;
              state_q <= S_RD;
            end else if (start_hint_i >= min_q) begin
              key_q   <= start_hint_i;
              state_q <= S_RD;
            end else begin
              gap_q   <= min_q - start_hint_i;
              state_q <= S_DIV;
            end
          end
        end

        S_DIV: begin
          quo_q   <= recip_prod[RECIP_SHIFT +: QUO_W];
          state_q <= S_REM;
        end

        S_REM: begin
          rem_q   <= rem_full[REM_W-1:0];
          state_q <= S_RAISE;
        end

        S_RAISE: begin
          if (raised[ID_W]) begin
            res_status_q <= ST_EXHAUSTED;
            state_q      <= S_EMIT;
          end else begin
            key_q   <= raised[ID_W-1:0];
            idx_q   <= '0;
            state_q <= S_RD;
          end
        end

        S_RD: begin
          state_q <= S_CMP;
        end

        S_CMP: begin
          // Lowest entry that holds no ID, for the final insert.
          if (!tbl_rd_valid && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= idx_q;
          end
          if (cmd_q == CMD_RELEASE) begin
            if (hit || last_entry) begin
              res_present_q <= hit;
              res_status_q  <= ST_RELEASED;
              state_q       <= S_EMIT;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_RD;
            end
          end else if (hit) begin
            // Candidate in use: step past it, failing when it wraps.
            if (key_q == '1) begin
              res_status_q <= ST_EXHAUSTED;
              state_q      <= S_EMIT;
            end else begin
              key_q   <= key_q + 1'b1;
              idx_q   <= '0;
              state_q <= S_RD;
            end
          end else if (last_entry) begin
            state_q <= S_FINISH;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_RD;
          end
        end

        S_FINISH: begin
          if (free_found_q) begin
            res_id_q     <= key_q;
            res_status_q <= ST_ALLOCATED;
          end else begin
            res_status_q <= ST_FULL;
          end
          state_q <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            given_id_q    <= res_id_q;
            status_q      <= res_status_q;
            was_present_q <= res_present_q;
            state_q       <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o   = (state_q == S_IDLE);
  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign given_id_o    = given_id_q;
  assign status_o      = status_q;
  assign was_present_o = was_present_q;

endmodule
